FILE: design/gcs_pkg.sv
// Package for the greedy change unit: denomination table and default widths.
// No dependencies; used by gcs_stage and greedy_change_with_stock_unit.
`default_nettype none

package gcs_pkg;

   localparam int DENOM_COUNT = 9;

   // largest first, the order in which change is paid out
   localparam int DENOM_VALUE [DENOM_COUNT] = '{500, 200, 100, 50, 20, 10, 5, 2, 1};

   localparam int DEFAULT_AMOUNT_WIDTH = 16;
   localparam int DEFAULT_COUNT_WIDTH  = 8;

endpackage : gcs_pkg

`default_nettype wire

FILE: design/greedy_change_with_stock_unit.sv
// Greedy change maker with limited stock: top level, nine chained gcs_stage blocks.
// Depends on gcs_pkg and gcs_stage.
//
//   channel   direction  handshake              word
//   req_      in         req_valid / req_stall  amount, have_500 .. have_1
//   rsp_      out        rsp_valid / rsp_stall  give_500 .. give_1, still_owed, shortfall
//
// One word accepted per cycle while the output is not stalled; a result passes through
// two register stages per denomination: reciprocal multiply, then min and subtract.
// Reset clears the valid bits only. A stalled output freezes the whole pipeline,
// and req_stall follows rsp_valid && rsp_stall.
`default_nettype none

module greedy_change_with_stock_unit #(
   parameter int AMOUNT_WIDTH = gcs_pkg::DEFAULT_AMOUNT_WIDTH,
   parameter int COUNT_WIDTH  = gcs_pkg::DEFAULT_COUNT_WIDTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [AMOUNT_WIDTH-1:0] req_amount,
   input  logic [COUNT_WIDTH-1:0]  req_have_500,
   input  logic [COUNT_WIDTH-1:0]  req_have_200,
   input  logic [COUNT_WIDTH-1:0]  req_have_100,
   input  logic [COUNT_WIDTH-1:0]  req_have_50,
   input  logic [COUNT_WIDTH-1:0]  req_have_20,
   input  logic [COUNT_WIDTH-1:0]  req_have_10,
   input  logic [COUNT_WIDTH-1:0]  req_have_5,
   input  logic [COUNT_WIDTH-1:0]  req_have_2,
   input  logic [COUNT_WIDTH-1:0]  req_have_1,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [COUNT_WIDTH-1:0]  rsp_give_500,
   output logic [COUNT_WIDTH-1:0]  rsp_give_200,
   output logic [COUNT_WIDTH-1:0]  rsp_give_100,
   output logic [COUNT_WIDTH-1:0]  rsp_give_50,
   output logic [COUNT_WIDTH-1:0]  rsp_give_20,
   output logic [COUNT_WIDTH-1:0]  rsp_give_10,
   output logic [COUNT_WIDTH-1:0]  rsp_give_5,
   output logic [COUNT_WIDTH-1:0]  rsp_give_2,
   output logic [COUNT_WIDTH-1:0]  rsp_give_1,
   output logic [AMOUNT_WIDTH-1:0] rsp_still_owed,
   output logic                    rsp_shortfall
);
   import gcs_pkg::*;

   logic                                      advance;
   logic [DENOM_COUNT:0]                      stage_valid;
   logic [AMOUNT_WIDTH-1:0]                   stage_rem [DENOM_COUNT+1];
   logic [DENOM_COUNT-1:0][COUNT_WIDTH-1:0]   stage_cnt [DENOM_COUNT+1];

   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   // entry: the count slot of each denomination holds the stock until its stage
   // replaces it with the pieces handed out
   assign stage_valid[0] = req_valid;
   assign stage_rem[0]   = req_amount;
   assign stage_cnt[0]   = {req_have_1, req_have_2, req_have_5, req_have_10, req_have_20,
                            req_have_50, req_have_100, req_have_200, req_have_500};

   for (genvar k = 0; k < DENOM_COUNT; k++) begin : g_denom
      gcs_stage #(
         .AMOUNT_WIDTH (AMOUNT_WIDTH),
         .COUNT_WIDTH  (COUNT_WIDTH),
         .IDX          (k)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (stage_valid[k]),
         .in_rem    (stage_rem[k]),
         .in_cnt    (stage_cnt[k]),
         .out_valid (stage_valid[k+1]),
         .out_rem   (stage_rem[k+1]),
         .out_cnt   (stage_cnt[k+1])
      );
   end

   assign rsp_valid      = stage_valid[DENOM_COUNT];
   assign rsp_still_owed = stage_rem[DENOM_COUNT];
   assign rsp_shortfall  = (stage_rem[DENOM_COUNT] != '0);
   assign rsp_give_500   = stage_cnt[DENOM_COUNT][0];
   assign rsp_give_200   = stage_cnt[DENOM_COUNT][1];
   assign rsp_give_100   = stage_cnt[DENOM_COUNT][2];
   assign rsp_give_50    = stage_cnt[DENOM_COUNT][3];
   assign rsp_give_20    = stage_cnt[DENOM_COUNT][4];
   assign rsp_give_10    = stage_cnt[DENOM_COUNT][5];
   assign rsp_give_5     = stage_cnt[DENOM_COUNT][6];
   assign rsp_give_2     = stage_cnt[DENOM_COUNT][7];
   assign rsp_give_1     = stage_cnt[DENOM_COUNT][8];

   // a stall freezes every valid bit in the chain
   a_freeze : assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$past(advance)) |-> $stable(stage_valid[DENOM_COUNT:1]))
      else $error("pipeline moved while stalled");

   for (genvar k = 0; k < DENOM_COUNT; k++) begin : g_check
      // a word in flight passes both registers of a stage to the next boundary when nothing stalls
      a_carry : assert property (@(posedge clock) disable iff (reset)
         (!$past(reset, 1) && !$past(reset, 2) && $past(advance, 1) && $past(advance, 2)
          && $past(stage_valid[k], 2)) |-> stage_valid[k+1])
         else $error("word lost between stages");

      // the amount owed never grows along the chain
      if (k > 0) begin : g_rem
         a_rem : assert property (@(posedge clock) disable iff (reset)
            (!$past(reset, 1) && !$past(reset, 2) && $past(advance, 1) && $past(advance, 2)
             && $past(stage_valid[k], 2)) |-> (stage_rem[k+1] <= $past(stage_rem[k], 2)))
            else $error("remainder grew in a stage");
      end
   end

endmodule : greedy_change_with_stock_unit

`default_nettype wire

FILE: design/gcs_stage.sv
// One denomination of the change pipeline: two register stages.
// Depends on gcs_pkg for the denomination table.
`default_nettype none

module gcs_stage #(
   parameter int AMOUNT_WIDTH = gcs_pkg::DEFAULT_AMOUNT_WIDTH,
   parameter int COUNT_WIDTH  = gcs_pkg::DEFAULT_COUNT_WIDTH,
   parameter int IDX          = 0
) (
   input  logic                                               clock,
   input  logic                                               reset,
   input  logic                                               advance,
   input  logic                                               in_valid,
   input  logic [AMOUNT_WIDTH-1:0]                            in_rem,
   input  logic [gcs_pkg::DENOM_COUNT-1:0][COUNT_WIDTH-1:0]   in_cnt,
   output logic                                               out_valid,
   output logic [AMOUNT_WIDTH-1:0]                            out_rem,
   output logic [gcs_pkg::DENOM_COUNT-1:0][COUNT_WIDTH-1:0]   out_cnt
);
   import gcs_pkg::*;

   localparam int Denom = DENOM_VALUE[IDX];
   localparam int Log2D = $clog2(Denom);
   localparam int Shift = AMOUNT_WIDTH + Log2D;
   localparam int MulW  = AMOUNT_WIDTH + 1;
   localparam int ProdW = AMOUNT_WIDTH + MulW;
   localparam int CmpW  = (AMOUNT_WIDTH > COUNT_WIDTH) ? AMOUNT_WIDTH : COUNT_WIDTH;
   // floor(2^Shift / Denom) + 1 gives an exact quotient for every AMOUNT_WIDTH-bit value
   localparam logic [63:0] RecipWide   = ((64'd1 << Shift) / 64'(Denom)) + 64'd1;
   localparam logic [MulW-1:0] Recip   = RecipWide[MulW-1:0];

   // first register stage: reciprocal product
   logic                                      a_valid_ff;
   logic [AMOUNT_WIDTH-1:0]                   a_rem_ff;
   logic [ProdW-1:0]                          a_prod_ff;
   logic [DENOM_COUNT-1:0][COUNT_WIDTH-1:0]   a_cnt_ff;
   logic [ProdW-1:0]                          a_prod_in;

   // second register stage: pieces taken and new remainder
   logic                                      b_valid_ff;
   logic [AMOUNT_WIDTH-1:0]                   b_rem_ff;
   logic [DENOM_COUNT-1:0][COUNT_WIDTH-1:0]   b_cnt_ff;
   logic [AMOUNT_WIDTH-1:0]                   b_rem_in;
   logic [DENOM_COUNT-1:0][COUNT_WIDTH-1:0]   b_cnt_in;

   logic [ProdW-1:0]                          prod_shifted;
   logic [CmpW-1:0]                           fit_ext;
   logic [CmpW-1:0]                           avail_ext;
   logic [CmpW-1:0]                           take_ext;

   assign a_prod_in = ProdW'(in_rem) * ProdW'(Recip);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_rem_ff  <= in_rem;
         a_prod_ff <= a_prod_in;
         a_cnt_ff  <= in_cnt;
      end
   end

   always_comb begin
      prod_shifted = a_prod_ff >> Shift;
      fit_ext      = CmpW'(prod_shifted[AMOUNT_WIDTH-1:0]);
      avail_ext    = CmpW'(a_cnt_ff[IDX]);
      take_ext     = (fit_ext < avail_ext) ? fit_ext : avail_ext;
      // take * Denom never exceeds the remainder, so it fits the amount width
      b_rem_in     = a_rem_ff - (AMOUNT_WIDTH'(take_ext) * AMOUNT_WIDTH'(Denom));
      b_cnt_in     = a_cnt_ff;
      b_cnt_in[IDX] = COUNT_WIDTH'(take_ext);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (advance) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         b_rem_ff <= b_rem_in;
         b_cnt_ff <= b_cnt_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_rem   = b_rem_ff;
   assign out_cnt   = b_cnt_ff;

endmodule : gcs_stage

`default_nettype wire
